// ===== design/pqsfs_pkg.sv =====
// Shared types, constants and helpers of the prompt queue serial frame sender.
`default_nettype none

package pqsfs_pkg;

   // Ring of queued prompts.
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // Item commands.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Fixed frame bytes.
   localparam logic [7:0] BYTE_START  = 8'h7E;
   localparam logic [7:0] BYTE_COUNT  = 8'h04;
   localparam logic [7:0] BYTE_SELECT = 8'h03;
   localparam logic [7:0] BYTE_END    = 8'hEF;

   // Bit positions inside one 8N1 character.
   localparam logic [3:0] BIT_START = 4'd0;
   localparam logic [3:0] BIT_STOP  = 4'd9;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_COUNT  = 3'd1,
      PH_SELECT = 3'd2,
      PH_HI     = 3'd3,
      PH_LO     = 3'd4,
      PH_END    = 3'd5
   } frame_phase_type;

   typedef struct packed {
      logic        cmd;
      logic [15:0] prompt;
      logic        busy_req;
   } req_item_type;

   typedef struct packed {
      logic tx_line;
      logic active;
      logic byte_done;
      logic frame_done;
   } rsp_item_type;

   // Byte of the frame that goes out in a given phase.
   function automatic logic [7:0] frame_byte(input frame_phase_type phase,
                                             input logic [15:0] value);
      logic [7:0] result;
      unique case (phase)
         PH_START:  result = BYTE_START;
         PH_COUNT:  result = BYTE_COUNT;
         PH_SELECT: result = BYTE_SELECT;
         PH_HI:     result = value[15:8];
         PH_LO:     result = value[7:0];
         default:   result = BYTE_END;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/pqsfs_core.sv =====
// Prompt ring and 8N1 frame state: one state update per accepted transaction.
`default_nettype none

module pqsfs_core
   import pqsfs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire req_item_type item,
   input  wire logic         quiet_mode,
   output rsp_item_type      result
);

   logic [15:0]     store [QUEUE_DEPTH];
   logic [15:0]     head_value_ff;
   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   frame_phase_type phase_ff, phase_in;
   logic [3:0]      bit_pos_ff, bit_pos_in;
   logic            line_ff, line_in;
   logic            sending_ff, sending_in;
   logic            push_go;
   logic            tick_go;
   logic            byte_done;
   logic            frame_done;
   logic [7:0]      cur_byte;
   logic [2:0]      bit_idx;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign push_go  = accept && (item.cmd == CMD_PUSH) && !quiet_mode;
   assign tick_go  = accept && (item.cmd == CMD_TICK) && sending_ff &&
                     !((phase_ff == PH_START) && item.busy_req);
   assign cur_byte = frame_byte(phase_ff, head_value_ff);
   assign bit_idx  = 3'(bit_pos_ff - 4'd1);

   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      phase_in     = phase_ff;
      bit_pos_in   = bit_pos_ff;
      line_in      = line_ff;
      sending_in   = sending_ff;
      byte_done    = 1'b0;
      frame_done   = 1'b0;
      if (push_go) begin
         write_ptr_in = ring_next(write_ptr_ff);
         sending_in   = 1'b1;
      end else if (tick_go) begin
         priority if (bit_pos_ff == BIT_START) begin
            line_in    = 1'b0;
            bit_pos_in = 4'd1;
         end else if (bit_pos_ff >= BIT_STOP) begin
            line_in    = 1'b1;
            bit_pos_in = BIT_START;
            byte_done  = 1'b1;
            if (phase_ff == PH_LO) begin
               read_ptr_in = ring_next(read_ptr_ff);
            end
            if (phase_ff >= PH_END) begin
               phase_in   = PH_START;
               frame_done = 1'b1;
               if (read_ptr_ff == write_ptr_ff) begin
                  sending_in = 1'b0;
               end
            end else begin
               phase_in = frame_phase_type'(phase_ff + 3'd1);
            end
         end else begin
            line_in    = cur_byte[bit_idx];
            bit_pos_in = bit_pos_ff + 4'd1;
         end
      end
   end

   assign result.tx_line    = line_in;
   assign result.active     = sending_in;
   assign result.byte_done  = byte_done;
   assign result.frame_done = frame_done;

   // The entry under the read pointer is kept in a register. A push that lands
   // on that entry is forwarded so the register always holds the newest value.
   always_ff @(posedge clock) begin
      if (push_go) begin
         store[write_ptr_ff] <= item.prompt + 16'd1;
      end
      if (push_go && (write_ptr_ff == read_ptr_in)) begin
         head_value_ff <= item.prompt + 16'd1;
      end else begin
         head_value_ff <= store[read_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         phase_ff     <= PH_START;
         bit_pos_ff   <= BIT_START;
         line_ff      <= 1'b1;
         sending_ff   <= 1'b0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         phase_ff     <= phase_in;
         bit_pos_ff   <= bit_pos_in;
         line_ff      <= line_in;
         sending_ff   <= sending_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pqsfs_out_buf.sv =====
// Result register with one skid entry between the core and the result channel.
`default_nettype none

module pqsfs_out_buf
   import pqsfs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_stall,
   input  wire rsp_item_type in_data,
   output logic              out_valid,
   input  wire logic         out_stall,
   output rsp_item_type      out_data
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   rsp_item_type skid_data_ff, skid_data_in;
   logic         accept;
   logic         out_free;

   assign accept   = in_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || accept;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== design/prompt_queue_serial_frame_sender_top.sv =====
// Top level of the prompt queue serial frame sender: ports, mode register, checks.
//
// The request channel (req_valid, req_stall, req_data) carries one transaction
// per item: a push queues prompt+1 in a 16-entry ring and wakes the sender, a
// tick drives one bit time of the 8N1 line through frames 7E 04 03 hi lo EF.
// Every request transaction yields exactly one response transaction on the
// rsp_ channel, holding the line level, the active flag and the byte and frame
// completion flags as they stand after that item.
// The response is registered in the response register, or in the skid entry
// while rsp_stall is held, and the block takes one transaction per cycle while
// req_stall is low; the sender's state is updated once per accepted item.
// The csr_ channel writes the quiet mode bit (pushes are dropped while it is
// set); csr_ready is always high and the bit takes effect at the next item.
// Reset empties the ring, parks the line high, clears quiet mode and drops any
// pending response. When the receiver holds rsp_stall, one more transaction is
// taken into a skid entry, after which req_stall rises until the response
// register is drained. Queue entries have no reset; only written ones are read.
`default_nettype none

module prompt_queue_serial_frame_sender_top
   import pqsfs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic         csr_data
);

   logic         quiet_ff, quiet_in;
   logic         req_accept;
   rsp_item_type core_result;

   // The mode register can always be written.
   assign csr_ready  = 1'b1;
   assign quiet_in   = (csr_valid && csr_ready) ? csr_data : quiet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff <= 1'b0;
      end else begin
         quiet_ff <= quiet_in;
      end
   end

   // A request is taken whenever the output buffer has room for its response.
   assign req_accept = req_valid && !req_stall;

   pqsfs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .item       (req_data),
      .quiet_mode (quiet_ff),
      .result     (core_result)
   );

   pqsfs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (core_result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // A full skid entry implies a waiting response.
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // Every accepted request leaves a response waiting in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no response");

   // A frame can only end on the stop bit of its last byte.
   a_frame_on_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |-> rsp_data.byte_done)
      else $error("frame end reported without a stop bit");

   // The stop bit leaves the line high.
   a_stop_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.byte_done) |-> rsp_data.tx_line)
      else $error("stop bit did not leave the line high");

endmodule

`default_nettype wire

// ===== verif/prompt_queue_serial_frame_sender_top_tb.sv =====
// Self-checking testbench of the prompt queue serial frame sender top level.
`timescale 1ns / 100ps

module prompt_queue_serial_frame_sender_top_tb;
   import pqsfs_pkg::*;

   // Longest run of cycles with no transaction on any channel before the run
   // is declared hung.
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_WAIT    = 12;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   prompt_queue_serial_frame_sender_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Our own picture of the sender. It is advanced once per accepted request
   // transaction, so it always describes the state after the newest item.
   logic [15:0]     prompt_ring [QUEUE_DEPTH] = '{default: '0};
   int unsigned     ring_wr = 0;
   int unsigned     ring_rd = 0;
   frame_phase_type tx_phase = PH_START;
   logic [3:0]      tx_bit = BIT_START;
   logic            tx_level = 1'b1;
   logic            tx_active = 1'b0;
   logic            quiet_mode = 1'b0;

   // Line states still owed by the block, oldest first.
   rsp_item_type    expected_line_states [$];

   int unsigned     mismatch_count = 0;
   int unsigned     sent_items = 0;
   // When set, the sender or the receiver runs without any idle cycles.
   bit              tx_calm = 1'b0;
   bit              rx_calm = 1'b0;
   int unsigned     rx_hold = 0;

   // Applies one item to the predicted state and returns the line state that
   // the block must report for it.
   function automatic rsp_item_type advance_sender(input req_item_type item);
      rsp_item_type outcome;
      logic [15:0]  held;
      logic [7:0]   frame [6];
      outcome = '0;
      if (item.cmd == CMD_PUSH) begin
         // A push in quiet mode leaves everything as it was.
         if (!quiet_mode) begin
            prompt_ring[ring_wr] = item.prompt + 16'd1;
            ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
            tx_active = 1'b1;
         end
      end else if (tx_active && !(tx_phase == PH_START && item.busy_req)) begin
         // The busy pin only holds back the first byte of a frame; ticks while
         // idle change nothing.
         if (tx_bit == BIT_START) begin
            tx_level = 1'b0;
            tx_bit = 4'd1;
         end else if (tx_bit == BIT_STOP) begin
            tx_level = 1'b1;
            tx_bit = BIT_START;
            outcome.byte_done = 1'b1;
            if (tx_phase == PH_LO) begin
               ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
            end
            if (tx_phase == PH_END) begin
               tx_phase = PH_START;
               outcome.frame_done = 1'b1;
               // A writer that lapped the reader makes the ring look empty here.
               if (ring_rd == ring_wr) begin
                  tx_active = 1'b0;
               end
            end else begin
               tx_phase = frame_phase_type'(tx_phase + 3'd1);
            end
         end else begin
            held = prompt_ring[ring_rd];
            frame = '{BYTE_START, BYTE_COUNT, BYTE_SELECT, held[15:8], held[7:0], BYTE_END};
            tx_level = frame[tx_phase][tx_bit - 4'd1];
            tx_bit = tx_bit + 4'd1;
         end
      end
      outcome.tx_line = tx_level;
      outcome.active = tx_active;
      return outcome;
   endfunction

   function automatic req_item_type make_item(input logic cmd, input logic [15:0] prompt,
                                              input logic busy);
      req_item_type item;
      item.cmd = cmd;
      item.prompt = prompt;
      item.busy_req = busy;
      return item;
   endfunction

   // Prompt numbers lean toward the two extremes, the rest is uniform.
   function automatic logic [15:0] pick_prompt();
      logic [15:0] value;
      case ($urandom_range(0, 7))
         0:       value = 16'h0000;
         1:       value = 16'hFFFF;
         default: value = 16'($urandom);
      endcase
      return value;
   endfunction

   function automatic void flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] MISMATCH: %s", $time, what);
      end
   endfunction

   // Sends one request transaction. The task is entered right after a rising
   // edge and returns at the edge where the transaction was accepted, leaving
   // valid high so that back-to-back items need no second assignment.
   task automatic send_item(input req_item_type item);
      int unsigned gap;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      expected_line_states.push_back(advance_sender(item));
      sent_items++;
   endtask

   // Lowers valid and waits until every owed response transaction has come.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_line_states.size() != 0);
   endtask

   // Writes the quiet mode bit. Only called after drain_results, so the block
   // has nothing in flight.
   task automatic write_quiet_mode(input logic value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      quiet_mode = value;
   endtask

   // Ticks until the predicted sender has gone idle, with the odd push landing
   // in the middle of a frame and the busy pin raised now and then.
   task automatic tick_until_idle();
      while (tx_active) begin
         if ($urandom_range(0, 99) == 0) begin
            send_item(make_item(CMD_PUSH, pick_prompt(), 1'($urandom)));
         end else begin
            send_item(make_item(CMD_TICK, 16'($urandom), $urandom_range(0, 5) == 0));
         end
      end
      repeat ($urandom_range(0, 3)) begin
         send_item(make_item(CMD_TICK, 16'($urandom), 1'($urandom)));
      end
   endtask

   // Ticks on an idle sender must leave the line high and inactive.
   task automatic test_idle_ticks();
      send_item(make_item(CMD_TICK, 16'h0000, 1'b0));
      send_item(make_item(CMD_TICK, 16'hFFFF, 1'b1));
   endtask

   // A push while muted must neither queue anything nor wake the sender.
   task automatic test_quiet_push();
      drain_results();
      write_quiet_mode(1'b1);
      send_item(make_item(CMD_PUSH, 16'h1234, 1'b0));
      send_item(make_item(CMD_TICK, 16'h0000, 1'b0));
      drain_results();
      write_quiet_mode(1'b0);
   endtask

   // The largest prompt wraps to zero when stored. The busy pin must hold the
   // start byte back, then be ignored once the count byte is under way.
   task automatic test_busy_start_byte();
      send_item(make_item(CMD_PUSH, 16'hFFFF, 1'b1));
      send_item(make_item(CMD_TICK, 16'h0000, 1'b1));
      repeat (11) send_item(make_item(CMD_TICK, 16'h0000, 1'b0));
      send_item(make_item(CMD_TICK, 16'hFFFF, 1'b1));
   endtask

   // A push in the middle of a frame only queues; the frame goes on.
   task automatic test_push_while_active();
      send_item(make_item(CMD_PUSH, 16'h0000, 1'b0));
      send_item(make_item(CMD_TICK, 16'h0000, 1'b0));
   endtask

   // Mostly well-formed traffic: a few pushes followed by enough ticks to send
   // every frame. Now and then a burst of 17 or 18 pushes laps the ring, and
   // some sequences are plain noise.
   task automatic test_random_traffic(input int unsigned budget);
      int unsigned stop_at;
      int unsigned burst;
      stop_at = sent_items + budget;
      while (sent_items < stop_at) begin
         tx_calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 8)) begin
                  send_item(make_item(1'($urandom), pick_prompt(), 1'($urandom)));
               end
            end
            2: begin
               burst = 17 + $urandom_range(0, 1);
               repeat (burst) send_item(make_item(CMD_PUSH, pick_prompt(), 1'($urandom)));
               tick_until_idle();
            end
            default: begin
               burst = $urandom_range(1, 3);
               repeat (burst) send_item(make_item(CMD_PUSH, pick_prompt(), 1'($urandom)));
               tick_until_idle();
            end
         endcase
      end
      tx_calm = 1'b0;
   endtask

   // Response side: check every accepted transaction against the oldest owed
   // line state, then draw how long to hold off the next one.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_line_states.size() == 0) begin
            flag_mismatch($sformatf("response with nothing owed: %b", rsp_data));
         end else begin
            want = expected_line_states.pop_front();
            if (want.tx_line !== rsp_data.tx_line || want.active !== rsp_data.active ||
                want.byte_done !== rsp_data.byte_done ||
                want.frame_done !== rsp_data.frame_done) begin
               flag_mismatch($sformatf(
                  {"expected tx_line=%b active=%b byte_done=%b frame_done=%b, ",
                   "got tx_line=%b active=%b byte_done=%b frame_done=%b"},
                  want.tx_line, want.active, want.byte_done, want.frame_done,
                  rsp_data.tx_line, rsp_data.active, rsp_data.byte_done,
                  rsp_data.frame_done));
            end
         end
         if ($urandom_range(0, 63) == 0) begin
            rx_calm = !rx_calm;
         end
         rx_hold = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rx_hold != 0) begin
         rx_hold--;
      end
      rsp_stall <= (rx_hold != 0);
   end

   // Watchdog: ends the run if no channel moves a transaction for too long.
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_quiet_push();
      test_busy_start_byte();
      test_push_while_active();

      // Random traffic in three runs: mode bit clear, set, clear. Each change
      // waits for the block to have nothing in flight. Every call runs a little
      // past its budget because the last sequence is always finished.
      test_random_traffic(950);
      drain_results();
      write_quiet_mode(1'b1);
      test_random_traffic(150);
      drain_results();
      write_quiet_mode(1'b0);
      test_random_traffic(400);

      drain_results();
      // The closing wait catches anything the block should not have sent.
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_line_states.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== prompt_queue_serial_frame_sender_top.f =====
design/pqsfs_pkg.sv
design/pqsfs_core.sv
design/pqsfs_out_buf.sv
design/prompt_queue_serial_frame_sender_top.sv
verif/prompt_queue_serial_frame_sender_top_tb.sv
